/* hw/rtl/jvs_pkg.sv */
// ----------------------------------------------------------------------------
// jvs_pkg
// Shared widths, constants, types and helpers of the joystick velocity shaper.
// ----------------------------------------------------------------------------
package jvs_pkg;

	localparam int RADIUS_W    = 10;
	localparam int ANGLE_W     = 12;
	localparam int BTN_W       = 4;
	localparam int VEL_W       = 25;
	localparam int TIER_W      = 2;
	localparam int LANE_W      = 16;
	localparam int TABLE_W     = 64;
	localparam int ALPHA_W     = 17;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [RADIUS_W-1:0] DEAD_ZONE   = 10'd200;
	localparam logic [RADIUS_W-1:0] RADIUS_FULL = 10'd1000;

	localparam logic [ANGLE_W-1:0] FWD_POS_LO  = 12'd300;
	localparam logic [ANGLE_W-1:0] FWD_POS_HI  = 12'd1500;
	localparam logic [ANGLE_W-1:0] FWD_NEG_LO  = 12'd2100;
	localparam logic [ANGLE_W-1:0] FWD_NEG_HI  = 12'd3300;
	localparam logic [ANGLE_W-1:0] TURN_POS_LO = 12'd1000;
	localparam logic [ANGLE_W-1:0] TURN_POS_HI = 12'd2600;
	localparam logic [ANGLE_W-1:0] TURN_NEG_LO = 12'd800;
	localparam logic [ANGLE_W-1:0] TURN_NEG_HI = 12'd2800;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	// floor(32 * p / 125) through a reciprocal, M = floor(2^37 / 125)
	localparam logic [30:0] RECIP_M     = 31'd1099511627;
	localparam int          RECIP_SHIFT = 32;
	localparam int          MAG_W       = 24;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CFG_FORWARD_CAPS    = 3'd0,
		CFG_TURN_CAPS       = 3'd1,
		CFG_FORWARD_STEPS   = 3'd2,
		CFG_TURN_STEPS      = 3'd3,
		CFG_SMOOTHING_ALPHA = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_MUL_Q,
		ST_CORR,
		ST_SLEW,
		ST_MUL_A,
		ST_ACC,
		ST_DONE
	} back_state_t;

	typedef struct packed {
		logic [TIER_W-1:0]   tier;
		logic                clr;
		logic [RADIUS_W-1:0] fwd_radius;
		logic                fwd_neg;
		logic [RADIUS_W-1:0] turn_radius;
		logic                turn_neg;
	} tick_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [LANE_W-1:0] lane(input logic [TABLE_W-1:0] tbl,
		input logic [TIER_W-1:0] tier);
		return tbl[LANE_W*tier +: LANE_W];
	endfunction

endpackage

/* hw/rtl/jvs_front.sv */
// ----------------------------------------------------------------------------
// jvs_front
// Takes input words, tracks the d-pad tier and classifies both sticks.
// ----------------------------------------------------------------------------
module jvs_front import jvs_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [RADIUS_W-1:0] left_radius,
	input  logic [ANGLE_W-1:0]  left_angle,
	input  logic [RADIUS_W-1:0] right_radius,
	input  logic [ANGLE_W-1:0]  right_angle,
	input  logic [BTN_W-1:0]    dpad_buttons,
	input  logic                clear_filters,
	input  queue_status_t       status,
	output logic                push,
	output tick_t               tick
);

	logic [TIER_W-1:0]   tier_q;
	logic [BTN_W-1:0]    last_q;
	logic [BTN_W-1:0]    rising;
	logic [TIER_W-1:0]   tier_next;
	logic [RADIUS_W-1:0] left_sat;
	logic [RADIUS_W-1:0] right_sat;

	assign in_ready = !status.full;
	assign push     = in_valid && in_ready;

	always_comb begin
		rising = dpad_buttons & ~last_q;
		if (rising[0]) begin
			tier_next = 2'd3;
		end else if (rising[1]) begin
			tier_next = 2'd0;
		end else if (rising[3]) begin
			tier_next = 2'd2;
		end else if (rising[2]) begin
			tier_next = 2'd1;
		end else begin
			tier_next = tier_q;
		end

		left_sat  = (left_radius > RADIUS_FULL) ? RADIUS_FULL : left_radius;
		right_sat = (right_radius > RADIUS_FULL) ? RADIUS_FULL : right_radius;

		tick             = '0;
		tick.tier        = tier_next;
		tick.clr         = clear_filters;

		if (left_radius > DEAD_ZONE) begin
			if (left_angle >= FWD_POS_LO && left_angle <= FWD_POS_HI) begin
				tick.fwd_radius = left_sat;
			end else if (left_angle >= FWD_NEG_LO && left_angle <= FWD_NEG_HI) begin
				tick.fwd_radius = left_sat;
				tick.fwd_neg    = 1'b1;
			end
		end

		// out-of-range right angles fall into the negative sector
		if (right_radius > DEAD_ZONE) begin
			if (right_angle >= TURN_POS_LO && right_angle <= TURN_POS_HI) begin
				tick.turn_radius = right_sat;
			end else if (right_angle <= TURN_NEG_LO || right_angle >= TURN_NEG_HI) begin
				tick.turn_radius = right_sat;
				tick.turn_neg    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tier_q <= '0;
			last_q <= '0;
		end else if (push) begin
			tier_q <= tier_next;
			last_q <= dpad_buttons;
		end
	end

endmodule

/* hw/rtl/jvs_queue.sv */
// ----------------------------------------------------------------------------
// jvs_queue
// Small word queue between the front and back parts.
// ----------------------------------------------------------------------------
module jvs_queue import jvs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tick_t         wr_tick,
	input  logic          pop,
	output tick_t         rd_tick,
	output queue_status_t status
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tick_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_tick      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!status.full || pop))
		else $error("push into full queue");
`endif

endmodule

/* hw/rtl/jvs_back.sv */
// ----------------------------------------------------------------------------
// jvs_back
// Sequencer with one shared multiplier: target scaling, slew limit and
// low-pass smoothing for the forward then the turn channel.
// ----------------------------------------------------------------------------
module jvs_back import jvs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  queue_status_t           status,
	input  tick_t                   rd_tick,
	output logic                    pop,
	input  logic [TABLE_W-1:0]      forward_caps,
	input  logic [TABLE_W-1:0]      turn_caps,
	input  logic [TABLE_W-1:0]      forward_steps,
	input  logic [TABLE_W-1:0]      turn_steps,
	input  logic [ALPHA_W-1:0]      smoothing_alpha,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VEL_W-1:0] forward_velocity,
	output logic signed [VEL_W-1:0] turn_velocity,
	output logic [TIER_W-1:0]       active_tier
);

	back_state_t              state_q;
	back_state_t              state_next;
	logic                     ch_q;
	tick_t                    cur_q;
	logic signed [58:0]       prod_q;
	logic [25:0]              p_q;
	logic signed [VEL_W-1:0]  target_q;
	logic signed [VEL_W-1:0]  lim_q [2];
	logic signed [VEL_W-1:0]  sm_q  [2];
	logic                     out_valid_q;
	logic signed [VEL_W-1:0]  fwd_out_q;
	logic signed [VEL_W-1:0]  turn_out_q;
	logic [TIER_W-1:0]        tier_out_q;

	logic [RADIUS_W-1:0]      radius_c;
	logic                     neg_c;
	logic [LANE_W-1:0]        cap_c;
	logic [LANE_W-1:0]        step_c;
	logic signed [VEL_W-1:0]  lim_c;
	logic signed [VEL_W-1:0]  sm_c;

	logic signed [31:0]       mul_a;
	logic signed [26:0]       mul_b;
	logic signed [58:0]       mul_p;

	logic [MAG_W-1:0]         q0;
	logic [31:0]              q0_ext;
	logic [31:0]              rem;
	logic [VEL_W-1:0]         mag;
	logic signed [VEL_W-1:0]  target_c;
	logic signed [26:0]       d;
	logic signed [26:0]       step27;
	logic signed [26:0]       slew_sum;
	logic signed [VEL_W-1:0]  lim_new;
	logic signed [25:0]       diff;
	logic signed [44:0]       acc;

	logic                     out_load;

	assign out_valid        = out_valid_q;
	assign forward_velocity = fwd_out_q;
	assign turn_velocity    = turn_out_q;
	assign active_tier      = tier_out_q;

	assign out_load = !out_valid_q || out_ready;

	// channel operand selection
	always_comb begin
		radius_c = ch_q ? cur_q.turn_radius : cur_q.fwd_radius;
		neg_c    = ch_q ? cur_q.turn_neg : cur_q.fwd_neg;
		cap_c    = lane(ch_q ? turn_caps : forward_caps, cur_q.tier);
		step_c   = lane(ch_q ? turn_steps : forward_steps, cur_q.tier);
		lim_c    = lim_q[ch_q];
		sm_c     = sm_q[ch_q];
	end

	// divide correction, slew and accumulate datapath
	always_comb begin
		q0       = prod_q[RECIP_SHIFT +: MAG_W];
		q0_ext   = {{(32-MAG_W){1'b0}}, q0};
		rem      = {1'b0, p_q, 5'b0} - ((q0_ext << 7) - (q0_ext << 2) + q0_ext);
		mag      = {1'b0, q0} + VEL_W'(rem >= 32'd125);
		target_c = neg_c ? -$signed(mag) : $signed(mag);

		d        = 27'(target_q) - 27'(lim_c);
		step27   = $signed({11'b0, step_c});
		slew_sum = 27'(lim_c) + step27;
		if (d > step27) begin
			lim_new = slew_sum[VEL_W-1:0];
		end else if (d < -step27) begin
			slew_sum = 27'(lim_c) - step27;
			lim_new  = slew_sum[VEL_W-1:0];
		end else begin
			lim_new = target_q;
		end

		diff = 26'(lim_c) - 26'(sm_c);
		acc  = (45'(sm_c) <<< 16) + 45'($signed(prod_q[42:0])) + 45'sd32768;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!status.empty) begin
					state_next = ST_MUL_P;
				end
			end
			ST_MUL_P: state_next = ST_MUL_Q;
			ST_MUL_Q: state_next = ST_CORR;
			ST_CORR:  state_next = ST_SLEW;
			ST_SLEW:  state_next = ST_MUL_A;
			ST_MUL_A: state_next = ST_ACC;
			ST_ACC:   state_next = ch_q ? ST_DONE : ST_MUL_P;
			ST_DONE: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: pop = !status.empty;
			ST_MUL_P: begin
				mul_a = $signed({16'b0, cap_c});
				mul_b = $signed({17'b0, radius_c});
			end
			ST_MUL_Q: begin
				mul_a = $signed({1'b0, RECIP_M});
				mul_b = $signed({1'b0, prod_q[25:0]});
			end
			ST_MUL_A: begin
				mul_a = $signed({15'b0, smoothing_alpha});
				mul_b = 27'(diff);
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == ST_IDLE) begin
			cur_q <= rd_tick;
		end
		if (state_q == ST_MUL_Q) begin
			p_q <= prod_q[25:0];
		end
		if (state_q == ST_CORR) begin
			target_q <= target_c;
		end
		if (state_q == ST_DONE && out_load) begin
			fwd_out_q  <= sm_q[0];
			turn_out_q <= sm_q[1];
			tier_out_q <= cur_q.tier;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			lim_q[0]    <= '0;
			lim_q[1]    <= '0;
			sm_q[0]     <= '0;
			sm_q[1]     <= '0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_IDLE: begin
					ch_q <= 1'b0;
					if (pop && rd_tick.clr) begin
						lim_q[0] <= '0;
						lim_q[1] <= '0;
						sm_q[0]  <= '0;
						sm_q[1]  <= '0;
					end
				end
				ST_SLEW: lim_q[ch_q] <= lim_new;
				ST_ACC: begin
					sm_q[ch_q] <= acc[16 +: VEL_W];
					ch_q       <= 1'b1;
				end
				default: begin
					ch_q <= ch_q;
				end
			endcase
			if (state_q == ST_DONE && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_recip_corr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CORR) |-> (rem < 32'd250))
		else $error("reciprocal quotient off by more than one");
	a_done_after_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ch_q)
		else $error("result finished before turn channel");
`endif

endmodule

/* hw/rtl/joystick_velocity_shaper_unit.sv */
// ----------------------------------------------------------------------------
// joystick_velocity_shaper_unit
// Joystick to chassis velocity shaper: tier select, targets, slew, low-pass.
// ----------------------------------------------------------------------------
// usage:
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the tier
//   cap and step tables and the smoothing weight; it is always ready; the
//   user must write it only while no tick is in flight; the block won't check
//   input channel (in_valid/in_ready) takes one tick word: stick readings,
//   d-pad bits and the clear flag; the front registers the d-pad tier and
//   pushes a classified word into a two-entry queue
//   output channel (out_valid/out_ready) returns one word per tick with both
//   smoothed velocities and the tier in use
//   the back sequencer loads a tick in its idle state, then for each channel
//   steps through MUL_P, MUL_Q, CORR, SLEW, MUL_A and ACC on the one shared
//   multiplier, hands off the result in DONE, then takes the next tick
//   while out_ready is low the result waits in the output register, the
//   back part holds its next result, and the front keeps taking ticks until
//   the queue is full
//   reset clears tier, button history, filter state and the tables, and
//   sets the smoothing weight to one
// ----------------------------------------------------------------------------
module joystick_velocity_shaper_unit import jvs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [RADIUS_W-1:0]     left_radius,
	input  logic [ANGLE_W-1:0]      left_angle,
	input  logic [RADIUS_W-1:0]     right_radius,
	input  logic [ANGLE_W-1:0]      right_angle,
	input  logic [BTN_W-1:0]        dpad_buttons,
	input  logic                    clear_filters,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VEL_W-1:0] forward_velocity,
	output logic signed [VEL_W-1:0] turn_velocity,
	output logic [TIER_W-1:0]       active_tier
);

	logic [TABLE_W-1:0] forward_caps_q;
	logic [TABLE_W-1:0] turn_caps_q;
	logic [TABLE_W-1:0] forward_steps_q;
	logic [TABLE_W-1:0] turn_steps_q;
	logic [ALPHA_W-1:0] alpha_q;
	logic [ALPHA_W-1:0] alpha_wr;

	queue_status_t status;
	logic          push;
	logic          pop;
	tick_t         wr_tick;
	tick_t         rd_tick;

	assign cfg_ready = 1'b1;
	assign alpha_wr  = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE : cfg_data[ALPHA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_caps_q  <= '0;
			turn_caps_q     <= '0;
			forward_steps_q <= '0;
			turn_steps_q    <= '0;
			alpha_q         <= ALPHA_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FORWARD_CAPS:    forward_caps_q  <= cfg_data;
				CFG_TURN_CAPS:       turn_caps_q     <= cfg_data;
				CFG_FORWARD_STEPS:   forward_steps_q <= cfg_data;
				CFG_TURN_STEPS:      turn_steps_q    <= cfg_data;
				CFG_SMOOTHING_ALPHA: alpha_q         <= alpha_wr;
				default: begin
					alpha_q <= alpha_q;
				end
			endcase
		end
	end

	jvs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.left_radius   (left_radius),
		.left_angle    (left_angle),
		.right_radius  (right_radius),
		.right_angle   (right_angle),
		.dpad_buttons  (dpad_buttons),
		.clear_filters (clear_filters),
		.status        (status),
		.push          (push),
		.tick          (wr_tick)
	);

	jvs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_tick (wr_tick),
		.pop     (pop),
		.rd_tick (rd_tick),
		.status  (status)
	);

	jvs_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.status           (status),
		.rd_tick          (rd_tick),
		.pop              (pop),
		.forward_caps     (forward_caps_q),
		.turn_caps        (turn_caps_q),
		.forward_steps    (forward_steps_q),
		.turn_steps       (turn_steps_q),
		.smoothing_alpha  (alpha_q),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.forward_velocity (forward_velocity),
		.turn_velocity    (turn_velocity),
		.active_tier      (active_tier)
	);

endmodule
